FILE: hw/rtl/fat12_cluster_table_engine_assert.svh
// Assertion macros for the FAT12 cluster table engine.
// Include from any RTL file that asserts; no other dependencies.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_ASSERT_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define F12CTE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("f12cte assertion failed");
// Clocked property, also checked during reset.
`define F12CTE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("f12cte assertion failed");
`else
`define F12CTE_ASSERT(lbl, clk, rstn, prop)
`define F12CTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/f12cte_pkg.sv
// Shared types and constants of the FAT12 cluster table engine.
// No dependencies.
`timescale 1ns / 1ps

package f12cte_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  localparam int unsigned CMD_W        = 3;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned ENTRY_W      = 12;
  localparam int unsigned USED_W       = 12;
  localparam int unsigned BYTES_W      = 13;
  localparam int unsigned FREE_BYTES_W = 25;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CMD_W-1:0] CMD_READ        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIRST_FREE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SECOND_FREE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FREE_BYTES  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_USED_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BYTES = 1'b1;

  localparam logic [USED_W-1:0]  USED_CLUSTERS_RST = 12'd713;
  localparam logic [BYTES_W-1:0] CLUSTER_BYTES_RST = 13'd1024;

  // Data clusters start at this table entry.
  localparam int unsigned FIRST_DATA_ENTRY = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic stop_on_hit;
    logic want_second;
  } scan_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [IDX_W-1:0]   nth;
    logic [USED_W-1:0]  count;
  } scan_stat_t;

endpackage

FILE: hw/rtl/f12cte_table_mem.sv
// Cluster table storage: one write port, one registered read port.
// Depends on f12cte_pkg.
`timescale 1ns / 1ps

module f12cte_table_mem
  import f12cte_pkg::*;
#(
  parameter  int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IW            = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IW-1:0]      waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [IW-1:0]      raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rdata_q;

  // Read-first: a read and a write to the same entry in one cycle return the old value.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/f12cte_scan.sv
// Free-entry scanner: walks the data entries through the table read port.
// Depends on f12cte_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fat12_cluster_table_engine_assert.svh"

module f12cte_scan
  import f12cte_pkg::*;
#(
  parameter  int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IW            = $clog2(TABLE_ENTRIES),
  localparam int unsigned CW            = $clog2(TABLE_ENTRIES + 1),
  localparam int unsigned SW            = (CW > USED_W + 1) ? CW : USED_W + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_ctrl_t         ctrl_i,
  input  logic [USED_W-1:0]  used_clusters_i,
  input  logic [ENTRY_W-1:0] rd_data_i,
  output logic               rd_en_o,
  output logic [IW-1:0]      rd_addr_o,
  output scan_stat_t         stat_o
);

  logic              run_q, pend_q, hit_q, stop_q, second_q;
  logic [USED_W-1:0] count_q;
  logic [SW-1:0]     addr_q, end_q, pend_addr_q;
  logic [IDX_W-1:0]  nth_q;

  logic              issue, is_free, take_hit, done;
  logic [SW-1:0]     span_sum, span_end;
  logic [USED_W-1:0] want_cnt;

  // Clip the scan window to the table.
  assign span_sum = SW'(used_clusters_i) + SW'(FIRST_DATA_ENTRY);
  assign span_end = (span_sum > SW'(TABLE_ENTRIES)) ? SW'(TABLE_ENTRIES) : span_sum;

  assign issue    = run_q && (addr_q < end_q) && !(stop_q && hit_q);
  assign is_free  = run_q && pend_q && (rd_data_i == '0);
  assign want_cnt = second_q ? USED_W'(1) : USED_W'(0);
  assign take_hit = is_free && stop_q && !hit_q && (count_q == want_cnt);
  assign done     = run_q && ((!issue && !pend_q) || (stop_q && hit_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      stop_q   <= 1'b0;
      second_q <= 1'b0;
      count_q  <= '0;
    end else if (ctrl_i.start) begin
      run_q    <= 1'b1;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      stop_q   <= ctrl_i.stop_on_hit;
      second_q <= ctrl_i.want_second;
      count_q  <= '0;
    end else if (run_q) begin
      if (done) begin
        run_q <= 1'b0;
      end
      pend_q <= issue;
      if (is_free) begin
        count_q <= count_q + USED_W'(1);
      end
      if (take_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      addr_q <= SW'(FIRST_DATA_ENTRY);
      end_q  <= span_end;
    end else if (issue) begin
      addr_q <= addr_q + SW'(1);
    end
    pend_addr_q <= addr_q;
    if (take_hit) begin
      nth_q <= pend_addr_q[IDX_W-1:0];
    end
  end

  assign rd_en_o      = issue;
  assign rd_addr_o    = addr_q[IW-1:0];
  assign stat_o.done  = done;
  assign stat_o.hit   = hit_q;
  assign stat_o.nth   = nth_q;
  assign stat_o.count = count_q;

  `F12CTE_ASSERT(a_issue_in_window, clk_i, rst_ni, rd_en_o |-> (addr_q < SW'(TABLE_ENTRIES)))
  `F12CTE_ASSERT(a_hit_needs_stop, clk_i, rst_ni, (run_q && hit_q) |-> stop_q)
  `F12CTE_ASSERT(a_pend_follows_issue, clk_i, rst_ni, (run_q && pend_q) |-> $past(rd_en_o))
  `F12CTE_ASSERT(a_done_ends_run, clk_i, rst_ni, (done && !ctrl_i.start) |=> !run_q)

endmodule

FILE: hw/rtl/fat12_cluster_table_engine.sv
// FAT12 cluster table engine top level: command sequencer, config, result register.
// Depends on f12cte_pkg, f12cte_table_mem, f12cte_scan and the assertion macro header.
`timescale 1ns / 1ps
`include "fat12_cluster_table_engine_assert.svh"

// Usage
//   Requests enter on the s_axis group: tuser carries the command, tdata the
//   entry index and entry value. Each request yields exactly one result on the
//   m_axis group: tdata holds read value, found index and free bytes, tuser the
//   not-found flag. Configuration (used clusters, cluster bytes) is written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i while the engine is idle.
// Timing
//   Read, write and remove: accept registers the request and ST_ACCESS loads
//   the result register; one request per cycle sustained while that register is
//   free. The table read port issues the read at accept and the write-back happens
//   with the result, so a request that hits the entry just written is forwarded.
//   Free scans: the table read port walks one entry per cycle over the
//   N = min(used_clusters, TABLE_ENTRIES-2) data entries, and the next request
//   is taken once the scan result is loaded; first and second free stop early
//   once the entry is found. Scans are taken one at a time.
// Reset
//   After reset a clearing pass zeroes every table entry, with s_axis_tready
//   low; configuration writes are taken during it.
// Stall
//   A result waits in the output register while m_axis_tready is low; the
//   engine holds the next finished request until the register frees up.
module fat12_cluster_table_engine
  import f12cte_pkg::*;
#(
  parameter  int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTES_W-1:0]   cfg_wdata_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // [11:0] entry_index, [23:12] entry_value
  input  logic [CMD_W-1:0]     s_axis_tuser,  // [2:0] command

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,  // [11:0] read_value, [23:12] found_index,
                                              // [48:24] free_bytes, [55:49] zero
  output logic                 m_axis_tuser   // [0] not_found
);

  // Configuration registers.
  logic [USED_W-1:0]  used_q;
  logic [BYTES_W-1:0] bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= USED_CLUSTERS_RST;
      bytes_q <= CLUSTER_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_USED_CLUSTERS: used_q  <= cfg_wdata_i[USED_W-1:0];
        REG_CLUSTER_BYTES: bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request fields.
  logic [IDX_W-1:0]   s_idx;
  logic [ENTRY_W-1:0] s_val;
  logic               s_in_tab, s_is_scan, accept;

  assign s_idx     = s_axis_tdata[IDX_W-1:0];
  assign s_val     = s_axis_tdata[IDX_W+ENTRY_W-1:IDX_W];
  assign s_in_tab  = {1'b0, s_idx} < (IDX_W + 1)'(TABLE_ENTRIES);
  assign s_is_scan = (s_axis_tuser == CMD_FIRST_FREE) || (s_axis_tuser == CMD_SECOND_FREE) ||
                     (s_axis_tuser == CMD_FREE_BYTES);
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Table memory and scanner.
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr, scan_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               scan_re;
  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;

  f12cte_table_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  f12cte_scan #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (scan_ctrl),
    .used_clusters_i (used_q),
    .rd_data_i       (mem_rdata),
    .rd_en_o         (scan_re),
    .rd_addr_o       (scan_raddr),
    .stat_o          (scan_stat)
  );

  // Sequencer state.
  state_e             state_q, state_d;
  logic [IW-1:0]      clr_q, clr_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [IDX_W-1:0]   idx_q;
  logic [ENTRY_W-1:0] val_q;
  logic               in_tab_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic [ENTRY_W-1:0] fwd_val_q;

  // Result register.
  logic                    out_valid_q, out_load, slot_free;
  logic [ENTRY_W-1:0]      rv_q, rv_d;
  logic [IDX_W-1:0]        fi_q, fi_d;
  logic [FREE_BYTES_W-1:0] fb_q, fb_d;
  logic                    nf_q, nf_d;
  logic [ENTRY_W-1:0]      acc_data;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign acc_data  = fwd_hit_q ? fwd_val_q : mem_rdata;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_q[IW-1:0];
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = s_idx[IW-1:0];
    scan_ctrl     = '0;
    fwd_hit_d     = 1'b0;
    out_load      = 1'b0;
    rv_d          = '0;
    fi_d          = '0;
    fb_d          = '0;
    nf_d          = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_ACCESS: begin
        if (slot_free) begin
          out_load      = 1'b1;
          s_axis_tready = 1'b1;
          state_d       = ST_IDLE;
          case (cmd_q)
            CMD_READ: begin
              if (in_tab_q) rv_d = acc_data;
            end
            CMD_WRITE: begin
              mem_we    = in_tab_q;
              mem_wdata = val_q;
            end
            CMD_REMOVE: begin
              if (in_tab_q) rv_d = acc_data;
              mem_we = in_tab_q;
            end
            default: ;
          endcase
          // The next request reads before this write lands: forward it.
          fwd_hit_d = mem_we && (s_idx == idx_q);
        end
      end
      ST_SCAN: begin
        mem_re    = scan_re;
        mem_raddr = scan_raddr;
        if (scan_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (cmd_q == CMD_FREE_BYTES) begin
            // count <= 4095 and bytes <= 8191: the product always fits, no clamp.
            fb_d = FREE_BYTES_W'(scan_stat.count) * FREE_BYTES_W'(bytes_q);
          end else if (scan_stat.hit) begin
            fi_d = scan_stat.nth;
          end else begin
            nf_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Take a new request: start a scan or issue the table read.
    if (accept) begin
      if (s_is_scan) begin
        state_d               = ST_SCAN;
        scan_ctrl.start       = 1'b1;
        scan_ctrl.stop_on_hit = (s_axis_tuser != CMD_FREE_BYTES);
        scan_ctrl.want_second = (s_axis_tuser == CMD_SECOND_FREE);
      end else begin
        state_d = ST_ACCESS;
        mem_re  = s_in_tab;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (accept) begin
        fwd_hit_q <= fwd_hit_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= s_axis_tuser;
      idx_q     <= s_idx;
      val_q     <= s_val;
      in_tab_q  <= s_in_tab;
      fwd_val_q <= mem_wdata;
    end
    if (out_load) begin
      rv_q <= rv_d;
      fi_q <= fi_d;
      fb_q <= fb_d;
      nf_q <= nf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, fb_q, fi_q, rv_q};
  assign m_axis_tuser  = nf_q;

  `F12CTE_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, (state_q == ST_CLEAR) |-> !s_axis_tready)
  `F12CTE_ASSERT(a_write_source, clk_i, rst_ni,
                 mem_we |-> (state_q == ST_CLEAR || state_q == ST_ACCESS))
  `F12CTE_ASSERT(a_accept_moves_on, clk_i, rst_ni,
                 accept |=> (state_q == ST_ACCESS || state_q == ST_SCAN))
  `F12CTE_ASSERT(a_load_source, clk_i, rst_ni,
                 out_load |-> (slot_free && (state_q == ST_ACCESS || state_q == ST_DONE)))
  `F12CTE_ASSERT(a_scan_port_owner, clk_i, rst_ni, scan_re |-> (state_q == ST_SCAN))

endmodule
